// ----- hw/rtl/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared opcodes, function codes and the result status type of the RV32I
// subset execute core.
// ----------------------------------------------------------------------------
package rvx_pkg;

   // Major opcodes of the supported instruction groups.
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;

   // funct7 codes of the register ALU group.
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // funct3 codes of the ALU group.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // funct3 codes of loads and stores.
   localparam logic [2:0] F3_BYTE   = 3'd0;
   localparam logic [2:0] F3_HALF   = 3'd1;
   localparam logic [2:0] F3_WORD   = 3'd2;
   localparam logic [2:0] F3_BYTE_U = 3'd4;
   localparam logic [2:0] F3_HALF_U = 3'd5;

   // funct3 codes of branches.
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // Base address of the data memory window.
   localparam logic [31:0] DATA_BASE = 32'h0000_0400;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EXTERNAL = 2'd1,
      STATUS_ILLEGAL  = 2'd2
   } status_type;

endpackage

// ----- hw/rtl/rvx_ram.sv -----
// ----------------------------------------------------------------------------
// rvx_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rv32i_subset_execute_core.sv -----
// ----------------------------------------------------------------------------
// rv32i_subset_execute_core
// Executes one RV32I instruction per request against a RAM based register
// file and a byte addressed data RAM, and returns the next PC and the
// register write of each instruction.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | req_instr_word
//   rsp     | out       | rsp_valid/rsp_stall  | next_pc, register write,
//           |           |                      | status, external access
//
// A request is not accepted while the previous one is in the execute stage:
// the register file RAM is read when a request is accepted, the execute
// stage executes and addresses the data RAM, and the write-back stage
// assembles load data and writes back. After reset the data RAM is
// cleared one row of four bytes per cycle; no request is taken meanwhile.
// A stalled response holds the write-back stage, which in turn holds off
// new requests; the response register lets the next request enter while a
// finished response waits.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_core #(
   parameter int DATA_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_write_value,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_external_address,
   output logic [31:0] rsp_external_store_data
);

   // The data memory is split into four byte lanes so that an unaligned
   // word touches each lane at most once.
   localparam int ROWS = (DATA_BYTES + 3) / 4;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [31:0] DATA_SIZE = 32'(DATA_BYTES);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   // ------------------------------------------------------------------
   // Pipeline control.
   // ------------------------------------------------------------------
   logic clr_busy_ff, clr_busy_in;
   logic [RW-1:0] clr_row_ff, clr_row_in;
   logic e_valid_ff;
   logic w_valid_ff;
   logic out_valid_ff;
   logic w_adv;
   logic accept;

   assign w_adv     = !out_valid_ff || !rsp_stall;
   assign req_stall = clr_busy_ff || e_valid_ff || (w_valid_ff && !w_adv);
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Register file: two RAM copies give the two source reads. Valid bits
   // stand for the reset value, and the last write is forwarded because a
   // read in the same cycle as that write returns the old data.
   // ------------------------------------------------------------------
   logic [31:0] rf_valid_ff, rf_valid_in;
   logic        fw_valid_ff, fw_valid_in;
   logic [4:0]  fw_idx_ff, fw_idx_in;
   logic [31:0] fw_val_ff, fw_val_in;
   logic        rf_wr_en;
   logic [4:0]  rf_wr_idx;
   logic [31:0] rf_wr_val;
   logic [31:0] rs1_q, rs2_q;

   rvx_ram #(.WIDTH(32), .DEPTH(32), .AW(5)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_idx),
      .wr_data (rf_wr_val),
      .rd_addr (req_instr_word[19:15]),
      .rd_data (rs1_q)
   );

   rvx_ram #(.WIDTH(32), .DEPTH(32), .AW(5)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_idx),
      .wr_data (rf_wr_val),
      .rd_addr (req_instr_word[24:20]),
      .rd_data (rs2_q)
   );

   // ------------------------------------------------------------------
   // Execute stage.
   // ------------------------------------------------------------------
   logic [31:0] e_instr_ff, e_instr_in;
   logic [31:0] pc_ff, pc_in;

   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd, rs1, rs2;
   logic [31:0] op_a, op_b;
   logic [31:0] imm_i, imm_s, imm_b, imm_j;
   logic [4:0]  sh;
   logic [31:0] addr, off;
   logic [2:0]  size;
   logic        in_window;
   logic        take;
   logic        ex_bad, ex_wr, ex_load, ex_store;
   logic [31:0] ex_val, ex_npc;
   rvx_pkg::status_type ex_status;

   // Write-back stage registers.
   logic        w_wr_ff, w_wr_in;
   logic        w_load_ff, w_load_in;
   logic [4:0]  w_rd_ff, w_rd_in;
   logic [31:0] w_val_ff, w_val_in;
   logic [31:0] w_npc_ff, w_npc_in;
   logic [2:0]  w_f3_ff, w_f3_in;
   logic [31:0] w_off_ff, w_off_in;
   logic [31:0] w_ext_addr_ff, w_ext_addr_in;
   logic [31:0] w_ext_data_ff, w_ext_data_in;
   rvx_pkg::status_type w_status_ff, w_status_in;

   always_comb begin
      opc = e_instr_ff[6:0];
      rd  = e_instr_ff[11:7];
      f3  = e_instr_ff[14:12];
      rs1 = e_instr_ff[19:15];
      rs2 = e_instr_ff[24:20];
      f7  = e_instr_ff[31:25];

      op_a = rf_valid_ff[rs1] ? rs1_q : 32'd0;
      if (fw_valid_ff && fw_idx_ff == rs1) begin
         op_a = fw_val_ff;
      end
      op_b = rf_valid_ff[rs2] ? rs2_q : 32'd0;
      if (fw_valid_ff && fw_idx_ff == rs2) begin
         op_b = fw_val_ff;
      end

      imm_i = {{20{e_instr_ff[31]}}, e_instr_ff[31:20]};
      imm_s = {{20{e_instr_ff[31]}}, e_instr_ff[31:25], e_instr_ff[11:7]};
      imm_b = {{19{e_instr_ff[31]}}, e_instr_ff[31], e_instr_ff[7],
               e_instr_ff[30:25], e_instr_ff[11:8], 1'b0};
      imm_j = {{11{e_instr_ff[31]}}, e_instr_ff[31], e_instr_ff[19:12],
               e_instr_ff[20], e_instr_ff[30:21], 1'b0};
      sh = op_b[4:0];

      addr = op_a + ((opc == rvx_pkg::OPC_STORE) ? imm_s : imm_i);
      off  = addr - rvx_pkg::DATA_BASE;
      case (f3[1:0])
         2'd0:    size = 3'd1;
         2'd1:    size = 3'd2;
         default: size = 3'd4;
      endcase
      in_window = (addr >= rvx_pkg::DATA_BASE) && (off <= DATA_SIZE - {29'd0, size});

      ex_bad    = 1'b0;
      ex_wr     = 1'b0;
      ex_load   = 1'b0;
      ex_store  = 1'b0;
      ex_val    = 32'd0;
      ex_npc    = pc_ff + 32'd4;
      ex_status = rvx_pkg::STATUS_OK;
      take      = 1'b0;

      case (opc)
         rvx_pkg::OPC_OP: begin
            ex_wr = 1'b1;
            if (f7 == rvx_pkg::F7_BASE) begin
               case (f3)
                  rvx_pkg::F3_ADD:  ex_val = op_a + op_b;
                  rvx_pkg::F3_SLL:  ex_val = op_a << sh;
                  rvx_pkg::F3_SLT:  ex_val = {31'd0, $signed(op_a) < $signed(op_b)};
                  rvx_pkg::F3_SLTU: ex_val = {31'd0, op_a < op_b};
                  rvx_pkg::F3_XOR:  ex_val = op_a ^ op_b;
                  rvx_pkg::F3_SRL:  ex_val = op_a >> sh;
                  rvx_pkg::F3_OR:   ex_val = op_a | op_b;
                  default:          ex_val = op_a & op_b;
               endcase
            end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_ADD) begin
               ex_val = op_a - op_b;
            end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_SRL) begin
               ex_val = 32'($signed(op_a) >>> sh);
            end else begin
               ex_bad = 1'b1;
            end
         end
         rvx_pkg::OPC_OP_IMM: begin
            ex_wr = 1'b1;
            case (f3)
               rvx_pkg::F3_ADD:  ex_val = op_a + imm_i;
               rvx_pkg::F3_SLT:  ex_val = {31'd0, $signed(op_a) < $signed(imm_i)};
               rvx_pkg::F3_SLTU: ex_val = {31'd0, op_a < imm_i};
               rvx_pkg::F3_XOR:  ex_val = op_a ^ imm_i;
               rvx_pkg::F3_OR:   ex_val = op_a | imm_i;
               rvx_pkg::F3_AND:  ex_val = op_a & imm_i;
               default:          ex_bad = 1'b1;
            endcase
         end
         rvx_pkg::OPC_LUI: begin
            ex_wr  = 1'b1;
            ex_val = {e_instr_ff[31:12], 12'd0};
         end
         rvx_pkg::OPC_LOAD: begin
            if (f3 == rvx_pkg::F3_BYTE || f3 == rvx_pkg::F3_HALF ||
                f3 == rvx_pkg::F3_WORD || f3 == rvx_pkg::F3_BYTE_U ||
                f3 == rvx_pkg::F3_HALF_U) begin
               if (in_window) begin
                  ex_wr   = 1'b1;
                  ex_load = 1'b1;
               end else begin
                  ex_status = rvx_pkg::STATUS_EXTERNAL;
               end
            end else begin
               ex_bad = 1'b1;
            end
         end
         rvx_pkg::OPC_STORE: begin
            if (f3 == rvx_pkg::F3_BYTE || f3 == rvx_pkg::F3_HALF ||
                f3 == rvx_pkg::F3_WORD) begin
               if (in_window) begin
                  ex_store = 1'b1;
               end else begin
                  ex_status = rvx_pkg::STATUS_EXTERNAL;
               end
            end else begin
               ex_bad = 1'b1;
            end
         end
         rvx_pkg::OPC_BRANCH: begin
            case (f3)
               rvx_pkg::F3_BEQ:  take = op_a == op_b;
               rvx_pkg::F3_BNE:  take = op_a != op_b;
               rvx_pkg::F3_BLT:  take = $signed(op_a) < $signed(op_b);
               rvx_pkg::F3_BGE:  take = $signed(op_a) >= $signed(op_b);
               rvx_pkg::F3_BLTU: take = op_a < op_b;
               rvx_pkg::F3_BGEU: take = op_a >= op_b;
               default:          ex_bad = 1'b1;
            endcase
            if (take) begin
               ex_npc = pc_ff + imm_b;
            end
         end
         rvx_pkg::OPC_JAL: begin
            ex_wr  = 1'b1;
            ex_val = pc_ff + 32'd4;
            ex_npc = pc_ff + imm_j;
         end
         rvx_pkg::OPC_JALR: begin
            if (f3 == rvx_pkg::F3_ADD) begin
               ex_wr  = 1'b1;
               ex_val = pc_ff + 32'd4;
               ex_npc = (op_a + imm_i) & ~32'd1;
            end else begin
               ex_bad = 1'b1;
            end
         end
         default: begin
            ex_bad = 1'b1;
         end
      endcase

      if (ex_bad) begin
         ex_wr     = 1'b0;
         ex_load   = 1'b0;
         ex_store  = 1'b0;
         ex_status = rvx_pkg::STATUS_ILLEGAL;
         ex_npc    = pc_ff;
      end
      if (rd == 5'd0) begin
         ex_wr = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Data memory: four byte lanes, each addressed at its own row so that an
   // unaligned access reads or writes all its bytes in the same cycle. Outside
   // the execute cycle the lanes keep reading the write-back stage's rows,
   // so load data stays put while a response is stalled.
   // ------------------------------------------------------------------
   logic [3:0]        lane_we;
   logic [RW-1:0]     lane_row [4];
   logic [7:0]        lane_wd [4];
   logic [7:0]        lane_q [4];

   always_comb begin
      logic [1:0]  idx;
      logic [31:0] byte_off;
      logic [31:0] mem_off;
      mem_off = e_valid_ff ? off : w_off_ff;
      for (int l = 0; l < 4; l++) begin
         idx         = 2'(l) - mem_off[1:0];
         byte_off    = mem_off + {30'd0, idx};
         lane_row[l] = byte_off[2 +: RW];
         lane_wd[l]  = 8'(op_b >> {idx, 3'b000});
         lane_we[l]  = e_valid_ff && ex_store && ({1'b0, idx} < size);
         if (clr_busy_ff) begin
            lane_row[l] = clr_row_ff;
            lane_wd[l]  = 8'd0;
            lane_we[l]  = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      rvx_ram #(.WIDTH(8), .DEPTH(ROWS), .AW(RW)) u_lane (
         .clock   (clock),
         .wr_en   (lane_we[g]),
         .wr_addr (lane_row[g]),
         .wr_data (lane_wd[g]),
         .rd_addr (lane_row[g]),
         .rd_data (lane_q[g])
      );
   end

   // ------------------------------------------------------------------
   // Write-back stage: assemble load data and write the register file.
   // ------------------------------------------------------------------
   logic [31:0] load_raw, wb_val;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         load_raw[8*i +: 8] = lane_q[2'(w_off_ff[1:0] + 2'(i))];
      end
      wb_val = w_val_ff;
      if (w_load_ff) begin
         case (w_f3_ff)
            rvx_pkg::F3_BYTE:   wb_val = {{24{load_raw[7]}}, load_raw[7:0]};
            rvx_pkg::F3_HALF:   wb_val = {{16{load_raw[15]}}, load_raw[15:0]};
            rvx_pkg::F3_BYTE_U: wb_val = {24'd0, load_raw[7:0]};
            rvx_pkg::F3_HALF_U: wb_val = {16'd0, load_raw[15:0]};
            default:            wb_val = load_raw;
         endcase
      end
   end

   assign rf_wr_en  = w_valid_ff && w_adv && w_wr_ff;
   assign rf_wr_idx = w_rd_ff;
   assign rf_wr_val = wb_val;

   // ------------------------------------------------------------------
   // Next-state logic.
   // ------------------------------------------------------------------
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + RW'(1);
         if (clr_row_ff == LAST_ROW) begin
            clr_busy_in = 1'b0;
         end
      end

      e_instr_in = accept ? req_instr_word : e_instr_ff;
      pc_in      = e_valid_ff ? ex_npc : pc_ff;

      rf_valid_in = rf_valid_ff;
      fw_valid_in = fw_valid_ff;
      fw_idx_in   = fw_idx_ff;
      fw_val_in   = fw_val_ff;
      if (rf_wr_en) begin
         rf_valid_in[rf_wr_idx] = 1'b1;
         fw_valid_in = 1'b1;
         fw_idx_in   = rf_wr_idx;
         fw_val_in   = rf_wr_val;
      end

      w_wr_in       = w_wr_ff;
      w_load_in     = w_load_ff;
      w_rd_in       = w_rd_ff;
      w_val_in      = w_val_ff;
      w_npc_in      = w_npc_ff;
      w_f3_in       = w_f3_ff;
      w_off_in      = w_off_ff;
      w_ext_addr_in = w_ext_addr_ff;
      w_ext_data_in = w_ext_data_ff;
      w_status_in   = w_status_ff;
      if (e_valid_ff) begin
         w_wr_in       = ex_wr;
         w_load_in     = ex_load;
         w_rd_in       = ex_wr ? rd : 5'd0;
         w_val_in      = ex_val;
         w_npc_in      = ex_npc;
         w_f3_in       = f3;
         w_off_in      = off;
         w_status_in   = ex_status;
         w_ext_addr_in = (ex_status == rvx_pkg::STATUS_EXTERNAL) ? addr : 32'd0;
         w_ext_data_in = (ex_status == rvx_pkg::STATUS_EXTERNAL && opc == rvx_pkg::OPC_STORE)
                         ? op_b : 32'd0;
      end
   end

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   logic [31:0] out_npc_ff;
   logic        out_wr_ff;
   logic [4:0]  out_rd_ff;
   logic [31:0] out_val_ff;
   logic [31:0] out_ext_addr_ff;
   logic [31:0] out_ext_data_ff;
   rvx_pkg::status_type out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_row_ff   <= '0;
         e_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= 32'd0;
         rf_valid_ff  <= 32'd0;
         fw_valid_ff  <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
         e_valid_ff  <= accept;
         if (e_valid_ff) begin
            w_valid_ff <= 1'b1;
         end else if (w_adv) begin
            w_valid_ff <= 1'b0;
         end
         if (w_valid_ff && w_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         pc_ff       <= pc_in;
         rf_valid_ff <= rf_valid_in;
         fw_valid_ff <= fw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_instr_ff    <= e_instr_in;
      fw_idx_ff     <= fw_idx_in;
      fw_val_ff     <= fw_val_in;
      w_wr_ff       <= w_wr_in;
      w_load_ff     <= w_load_in;
      w_rd_ff       <= w_rd_in;
      w_val_ff      <= w_val_in;
      w_npc_ff      <= w_npc_in;
      w_f3_ff       <= w_f3_in;
      w_off_ff      <= w_off_in;
      w_ext_addr_ff <= w_ext_addr_in;
      w_ext_data_ff <= w_ext_data_in;
      w_status_ff   <= w_status_in;
      if (w_valid_ff && w_adv) begin
         out_npc_ff      <= w_npc_ff;
         out_wr_ff       <= w_wr_ff;
         out_rd_ff       <= w_rd_ff;
         out_val_ff      <= w_wr_ff ? wb_val : 32'd0;
         out_status_ff   <= w_status_ff;
         out_ext_addr_ff <= w_ext_addr_ff;
         out_ext_data_ff <= w_ext_data_ff;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_next_pc             = out_npc_ff;
   assign rsp_reg_written         = out_wr_ff;
   assign rsp_dest_index          = out_rd_ff;
   assign rsp_write_value         = out_val_ff;
   assign rsp_status              = out_status_ff;
   assign rsp_external_address    = out_ext_addr_ff;
   assign rsp_external_store_data = out_ext_data_ff;

endmodule

// ----- hw/rtl/rvx_checker.sv -----
// ----------------------------------------------------------------------------
// rvx_checker
// Port level checks of the RV32I subset execute core.
// ----------------------------------------------------------------------------
module rvx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_reg_written,
   input logic [4:0]  rsp_dest_index,
   input logic [31:0] rsp_write_value,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_external_address,
   input logic [31:0] rsp_external_store_data
);

   // A response that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // An accepted request occupies the execute stage for the next cycle.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted in back to back cycles");

   // Without a register write, the write fields read as zero.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_dest_index == 5'd0 && rsp_write_value == 32'd0)
      else $error("write fields set without a register write");

   // An illegal encoding writes nothing and hands out nothing.
   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rvx_pkg::STATUS_ILLEGAL |->
         !rsp_reg_written && rsp_external_address == 32'd0)
      else $error("illegal encoding had side effects");

   // Store data is only handed out with an external access.
   a_ext_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rvx_pkg::STATUS_EXTERNAL |-> rsp_external_store_data == 32'd0)
      else $error("store data shown without an external access");

endmodule

bind rv32i_subset_execute_core rvx_checker u_rvx_checker (.*);
